@@ rtl/coalescing_event_queue_core_macros.svh @@
// assertion macros used by coalescing_event_queue_core.sv
`ifndef COALESCING_EVENT_QUEUE_CORE_MACROS_SVH
`define COALESCING_EVENT_QUEUE_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define CEQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ceq check failed");

// next-cycle implication, checked out of reset
`define CEQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ceq check failed");

`endif

@@ rtl/ceq_pkg.sv @@
package ceq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int DROP_LEVEL = QUEUE_DEPTH - 2;

  typedef enum logic [2:0] {
    ST_APPENDED = 3'd0,
    ST_MERGED   = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_DEQUEUED = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } mode_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  command;
    logic [7:0]  object_type;
    logic [7:0]  object_index;
    logic [15:0] data_value;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  out_command;
    logic [7:0]  out_object_type;
    logic [7:0]  out_object_index;
    logic [15:0] out_data_value;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  command;
    logic [7:0]  object_type;
    logic [7:0]  object_index;
    logic [15:0] data_value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SEARCH,
    S_DEQ_DATA,
    S_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    search_start;
    logic    search_step;
    logic    merge;
    logic    append;
    logic    deq_read;
    logic    deq_finish;
    logic    set_res;
    status_t res_code;
    logic    publish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mode;
    logic empty;
    logic full;
    logic hit;
    logic done;
    logic out_free;
  } dp_sts_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

endpackage

@@ rtl/coalescing_event_queue_core.sv @@
// Coalescing ring queue of display event frames, one result per input item.
// An enqueue is dropped when QUEUE_DEPTH - 2 frames are held; otherwise the
// held frames are searched newest to oldest for the same command, object type
// and object index, and a match only takes the new data, else the frame is
// appended. A dequeue returns the oldest frame or reports empty. Items are
// handled one at a time. An item is loaded in S_IDLE and checked in S_CHECK;
// an empty dequeue or a drop then goes straight to S_RESULT, a dequeue reads
// the oldest frame in S_DEQ_DATA, and an enqueue reads the held frames in
// S_SEARCH until a match or until all are read. S_RESULT moves the result
// into the output register once that is free, so a stalled output holds it
// back there. The search rate is set by the single read port of the entry
// memory, one entry per cycle. The next item is taken while a finished
// result still waits in the output register.
`include "coalescing_event_queue_core_macros.svh"

module coalescing_event_queue_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ceq_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ceq_pkg::out_item_t  out_data
);

  import ceq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ceq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  ceq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  `CEQ_ASSERT_NOW(a_publish_free, cmd.publish, (!out_valid || out_ready))
  `CEQ_ASSERT_NOW(a_one_update, 1'b1, $onehot0({cmd.merge, cmd.append, cmd.deq_finish}))
  `CEQ_ASSERT_NOW(a_append_room, cmd.append, !sts.full)
  `CEQ_ASSERT_NEXT(a_publish_valid, cmd.publish, out_valid)

endmodule

@@ rtl/ceq_ram.sv @@
module ceq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/ceq_dp.sv @@
module ceq_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  ceq_pkg::in_item_t   in_data,
  input  ceq_pkg::dp_cmd_t    cmd,
  output ceq_pkg::dp_sts_t    sts,
  output logic                out_valid,
  input  logic                out_ready,
  output ceq_pkg::out_item_t  out_data
);

  import ceq_pkg::*;

  in_item_t         item_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [PTR_W-1:0] sptr_r, sptr_nxt;
  logic [CNT_W-1:0] scnt_r, scnt_nxt;
  logic             pend_r, pend_nxt;
  logic [PTR_W-1:0] paddr_r, paddr_nxt;
  out_item_t        res_r;
  out_item_t        out_r;
  logic             out_valid_r, out_valid_nxt;

  logic             ram_we, ram_re;
  logic [PTR_W-1:0] ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  entry_t           rd_entry;
  entry_t           wr_entry;
  logic             issue;

  assign rd_entry = entry_t'(ram_rdata);

  assign wr_entry.command      = item_r.command;
  assign wr_entry.object_type  = item_r.object_type;
  assign wr_entry.object_index = item_r.object_index;
  assign wr_entry.data_value   = item_r.data_value;

  assign issue     = cmd.search_step && (scnt_r != '0);
  assign ram_re    = cmd.deq_read || issue;
  assign ram_raddr = cmd.deq_read ? rptr_r : ptr_prev(sptr_r);
  assign ram_we    = cmd.merge || cmd.append;
  assign ram_waddr = cmd.merge ? paddr_r : wptr_r;
  assign ram_wdata = ENTRY_W'(wr_entry);

  ceq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    sts.mode     = item_r.mode;
    sts.empty    = (cnt_r == '0);
    sts.full     = (cnt_r >= CNT_W'(DROP_LEVEL));
    sts.hit      = pend_r
                   && (rd_entry.command == item_r.command)
                   && (rd_entry.object_type == item_r.object_type)
                   && (rd_entry.object_index == item_r.object_index);
    sts.done     = !pend_r && (scnt_r == '0);
    sts.out_free = !out_valid_r || out_ready;
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    wptr_nxt      = wptr_r;
    rptr_nxt      = rptr_r;
    sptr_nxt      = sptr_r;
    scnt_nxt      = scnt_r;
    pend_nxt      = pend_r;
    paddr_nxt     = paddr_r;
    out_valid_nxt = out_valid_r;

    if (cmd.search_start) begin
      sptr_nxt = wptr_r;
      scnt_nxt = cnt_r;
      pend_nxt = 1'b0;
    end
    // newest to oldest, one read issued and one compared per cycle
    if (cmd.search_step) begin
      pend_nxt = issue;
      if (issue) begin
        sptr_nxt  = ptr_prev(sptr_r);
        paddr_nxt = ptr_prev(sptr_r);
        scnt_nxt  = scnt_r - 1'b1;
      end
    end
    if (cmd.append) begin
      wptr_nxt = ptr_next(wptr_r);
      cnt_nxt  = cnt_r + 1'b1;
    end
    if (cmd.deq_finish) begin
      rptr_nxt = ptr_next(rptr_r);
      cnt_nxt  = cnt_r - 1'b1;
    end
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      wptr_r      <= '0;
      rptr_r      <= '0;
      sptr_r      <= '0;
      scnt_r      <= '0;
      pend_r      <= 1'b0;
      paddr_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      wptr_r      <= wptr_nxt;
      rptr_r      <= rptr_nxt;
      sptr_r      <= sptr_nxt;
      scnt_r      <= scnt_nxt;
      pend_r      <= pend_nxt;
      paddr_r     <= paddr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.set_res) begin
      res_r.status <= cmd.res_code;
      if (cmd.deq_finish) begin
        res_r.out_command      <= rd_entry.command;
        res_r.out_object_type  <= rd_entry.object_type;
        res_r.out_object_index <= rd_entry.object_index;
        res_r.out_data_value   <= rd_entry.data_value;
      end else begin
        res_r.out_command      <= '0;
        res_r.out_object_type  <= '0;
        res_r.out_object_index <= '0;
        res_r.out_data_value   <= '0;
      end
    end
    if (cmd.publish) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/ceq_ctrl.sv @@
module ceq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ceq_pkg::dp_sts_t  sts,
  output ceq_pkg::dp_cmd_t  cmd
);

  import ceq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res_code = ST_APPENDED;
    in_ready  = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.mode == MODE_DEQ) begin
          if (sts.empty) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_EMPTY;
            state_nxt    = S_RESULT;
          end else begin
            cmd.deq_read = 1'b1;
            state_nxt    = S_DEQ_DATA;
          end
        end else if (sts.full) begin
          // full check comes before any search
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_DROPPED;
          state_nxt    = S_RESULT;
        end else begin
          cmd.search_start = 1'b1;
          state_nxt        = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts.hit) begin
          cmd.merge    = 1'b1;
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_MERGED;
          state_nxt    = S_RESULT;
        end else if (sts.done) begin
          cmd.append   = 1'b1;
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_APPENDED;
          state_nxt    = S_RESULT;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      S_DEQ_DATA: begin
        cmd.deq_finish = 1'b1;
        cmd.set_res    = 1'b1;
        cmd.res_code   = ST_DEQUEUED;
        state_nxt      = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
